// ----- design/two_pass_component_labeler_defines.svh -----
// Assertion macros for the two-pass component labeler.
// Included by tpcl_datapath, which carries the concurrent checks; no other dependencies.
`ifndef TWO_PASS_COMPONENT_LABELER_DEFINES_SVH
`define TWO_PASS_COMPONENT_LABELER_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every rising clk_i edge outside reset
`define TPCL_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tpcl assertion failed");
// Check that a condition never holds outside reset
`define TPCL_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tpcl forbidden condition seen");
`else
`define TPCL_ASSERT(name, prop)
`define TPCL_ASSERT_NEVER(name, cond)
`endif
`endif

// ----- design/tpcl_pkg.sv -----
// Shared types and constants of the two-pass component labeler.
// No dependencies; imported by the interfaces, top level, controller and datapath.
`default_nettype none
package tpcl_pkg;

  // Sizes
  localparam int MaxWidth   = 1024;
  localparam int LabelCount = 256;
  localparam int LabelW     = 8;
  localparam int WidthW     = 11;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int FillW      = $clog2(MaxWidth + 1);
  localparam int LabelMax   = (LabelCount > 256) ? 255 : LabelCount - 1;
  localparam int WidthReset = 640;
  localparam int WidthMin   = 2;

  // Item kinds
  localparam logic KindPixel   = 1'b0;
  localparam logic KindResolve = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_PIX_EVAL,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_COMMIT,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    WALK_LEFT,
    WALK_UP,
    WALK_QUERY
  } walk_sel_e;

  typedef struct packed {
    logic              kind;
    logic              start_of_frame;
    logic              pixel_on;
    logic [LabelW-1:0] label_query;
  } tpcl_item_t;

  typedef struct packed {
    logic [LabelW-1:0] label;
    logic              overflow;
  } tpcl_result_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic eval;
    logic walk_step;
    logic walk_to_up;
    logic link;
    logic resolve;
    logic commit;
    logic out_load;
  } tpcl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_merge;
    logic root_found;
    logic out_free;
  } tpcl_status_t;

endpackage
`default_nettype wire

// ----- design/tpcl_ifs.sv -----
// Valid/ready channel interfaces for labeler input items and results.
// Depends on tpcl_pkg for field widths.
`default_nettype none
interface tpcl_in_if;
  import tpcl_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic              start_of_frame;
  logic              pixel_on;
  logic [LabelW-1:0] label_query;

  modport source (output valid, kind, start_of_frame, pixel_on, label_query,
                  input ready);
  modport sink (input valid, kind, start_of_frame, pixel_on, label_query,
                output ready);
endinterface

interface tpcl_out_if;
  import tpcl_pkg::*;
  logic              valid;
  logic              ready;
  logic [LabelW-1:0] label;
  logic              overflow;

  modport source (output valid, label, overflow, input ready);
  modport sink (input valid, label, overflow, output ready);
endinterface
`default_nettype wire

// ----- design/two_pass_component_labeler.sv -----
// Top level of the two-pass connected component labeler (4-connectivity).
// Depends on tpcl_pkg, tpcl_ifs, tpcl_ctrl and tpcl_datapath.
`default_nettype none
// The block handles one item at a time. A pixel item (kind 0) passes through
// row read, evaluation, commit and the output state when no merge is needed;
// when both neighbors are labeled it first walks the left and then the upper
// label to its root and links the two roots. A resolve item (kind 1) walks
// the chain from the queried label to its root and then hands off the result.
// The parent table is a RAM with registered read, so each chain step takes a
// read state and a check state. A result that is not taken holds back the next
// item while it waits in the output register. The row buffer uses a fill
// count and the parent table per-entry valid bits, so neither reset nor start
// of frame needs a clearing pass. Width writes take effect at the next accept or commit.
module two_pass_component_labeler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tpcl_pkg::WidthW-1:0] cfg_wdata_i,
  tpcl_in_if.sink                          in_if,
  tpcl_out_if.source                       out_if
);
  import tpcl_pkg::*;

  tpcl_item_t   item;
  tpcl_result_t res;
  tpcl_cmd_t    cmd;
  tpcl_status_t status;
  logic         in_ready;
  logic         out_valid;

  // Gather the input beat
  assign item.kind           = in_if.kind;
  assign item.start_of_frame = in_if.start_of_frame;
  assign item.pixel_on       = in_if.pixel_on;
  assign item.label_query    = in_if.label_query;
  assign in_if.ready         = in_ready;

  // Drive the result beat
  assign out_if.valid    = out_valid;
  assign out_if.label    = res.label;
  assign out_if.overflow = res.overflow;

  tpcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_kind_i  (in_if.kind),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tpcl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .res_o       (res)
  );

endmodule
`default_nettype wire

// ----- design/tpcl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tpcl_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- design/tpcl_ctrl.sv -----
// Sequencer of the labeler: steps one item through row read, chain walks,
// table link, commit and result hand-off. Depends on tpcl_pkg.
`default_nettype none
module tpcl_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_kind_i,
  output logic                        in_ready_o,
  input  wire tpcl_pkg::tpcl_status_t status_i,
  output tpcl_pkg::tpcl_cmd_t         cmd_o
);
  import tpcl_pkg::*;

  ctrl_state_e state_q, state_d;
  walk_sel_e   walk_q, walk_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      walk_q  <= WALK_LEFT;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    walk_d  = walk_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KindPixel) begin
            state_d = ST_ROW_RD;
          end else begin
            walk_d  = WALK_QUERY;
            state_d = ST_WALK_RD;
          end
        end
      end
      ST_ROW_RD: state_d = ST_PIX_EVAL;
      ST_PIX_EVAL: begin
        if (status_i.need_merge) begin
          walk_d  = WALK_LEFT;
          state_d = ST_WALK_RD;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_WALK_RD: state_d = ST_WALK_CHK;
      ST_WALK_CHK: begin
        if (!status_i.root_found) begin
          state_d = ST_WALK_RD;
        end else begin
          unique case (walk_q)
            WALK_LEFT: begin
              walk_d  = WALK_UP;
              state_d = ST_WALK_RD;
            end
            WALK_UP:    state_d = ST_COMMIT;
            WALK_QUERY: state_d = ST_OUT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_COMMIT: state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_ROW_RD: ;
      ST_PIX_EVAL: cmd_o.eval = 1'b1;
      ST_WALK_RD: ;
      ST_WALK_CHK: begin
        if (!status_i.root_found) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          cmd_o.walk_to_up = (walk_q == WALK_LEFT);
          cmd_o.link       = (walk_q == WALK_UP);
          cmd_o.resolve    = (walk_q == WALK_QUERY);
        end
      end
      ST_COMMIT: cmd_o.commit = 1'b1;
      ST_OUT:    cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/tpcl_datapath.sv -----
// Labeler datapath: position and label counters, row label buffer, parent
// table with valid bits, chain walk register and result register.
// Depends on tpcl_pkg, tpcl_ram and the assertion macros header.
`default_nettype none
`include "two_pass_component_labeler_defines.svh"
module tpcl_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tpcl_pkg::WidthW-1:0] cfg_wdata_i,
  input  wire tpcl_pkg::tpcl_item_t        item_i,
  input  wire tpcl_pkg::tpcl_cmd_t         cmd_i,
  output tpcl_pkg::tpcl_status_t           status_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output tpcl_pkg::tpcl_result_t           res_o
);
  import tpcl_pkg::*;

  // Control state (reset)
  logic [WidthW-1:0]     image_width_q, image_width_d;
  logic [ColW-1:0]       col_q, col_d;
  logic                  first_q, first_d;
  logic [LabelW-1:0]     left_q, left_d;
  logic [LabelW-1:0]     next_label_q, next_label_d;
  logic                  ovf_q, ovf_d;
  logic [FillW-1:0]      fill_q, fill_d;
  logic [LabelCount-1:0] pvalid_q, pvalid_d;
  logic                  out_valid_q, out_valid_d;

  // Payload registers
  logic              pix_q, pix_d;
  logic [LabelW-1:0] lab_q, lab_d;
  logic [LabelW-1:0] cur_q, cur_d;
  logic [LabelW-1:0] up_q, up_d;
  logic [LabelW-1:0] ra_q, ra_d;
  logic              prd_valid_q;
  tpcl_result_t      res_q, res_d;

  logic [WidthW-1:0] w_use;
  logic [LabelW-1:0] row_rdata, par_rdata, par_val, up_lab;
  logic              pixel_fg, do_link;
  logic [ColW-1:0]   col_base;
  logic              first_base;
  logic [LabelW-1:0] left_base;
  logic [WidthW-1:0] col_next;

  // Clamp the configured width to the supported range
  always_comb begin
    if (image_width_q < WidthW'(WidthMin)) begin
      w_use = WidthW'(WidthMin);
    end else if (image_width_q > WidthW'(MaxWidth)) begin
      w_use = WidthW'(MaxWidth);
    end else begin
      w_use = image_width_q;
    end
  end

  // Row entries past the fill mark were not written this frame and read as zero
  assign up_lab   = ({1'b0, col_q} < fill_q) ? row_rdata : '0;
  assign par_val  = prd_valid_q ? par_rdata : '0;
  assign pixel_fg = pix_q && !first_q && (col_q != '0);
  assign do_link  = cmd_i.link && (ra_q != cur_q);
  assign col_next = WidthW'(col_q) + WidthW'(1);

  assign status_o.need_merge = pixel_fg && (left_q != '0) && (up_lab != '0);
  assign status_o.root_found = (par_val == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Next-state logic
  always_comb begin
    image_width_d = image_width_q;
    col_d         = col_q;
    first_d       = first_q;
    left_d        = left_q;
    next_label_d  = next_label_q;
    ovf_d         = ovf_q;
    fill_d        = fill_q;
    pvalid_d      = pvalid_q;
    pix_d         = pix_q;
    lab_d         = lab_q;
    cur_d         = cur_q;
    up_d          = up_q;
    ra_d          = ra_q;
    res_d         = res_q;
    col_base      = col_q;
    first_base    = first_q;
    left_base     = left_q;

    if (cfg_we_i) begin
      image_width_d = cfg_wdata_i;
    end

    // Accept: for a pixel item, frame start clears, then wrap if the width shrank
    if (cmd_i.accept) begin
      lab_d = '0;
      pix_d = item_i.pixel_on;
      cur_d = item_i.label_query;
      if (item_i.kind == KindPixel) begin
        if (item_i.start_of_frame) begin
          col_base     = '0;
          first_base   = 1'b1;
          left_base    = '0;
          next_label_d = '0;
          ovf_d        = 1'b0;
          fill_d       = '0;
          pvalid_d     = '0;
        end
        if ({1'b0, col_base} >= w_use) begin
          col_d   = '0;
          first_d = 1'b0;
          left_d  = '0;
        end else begin
          col_d   = col_base;
          first_d = first_base;
          left_d  = left_base;
        end
      end
    end

    // Provisional label from the left and upper neighbors
    if (cmd_i.eval) begin
      up_d  = up_lab;
      cur_d = left_q;
      if (pixel_fg) begin
        if (left_q == '0 && up_lab == '0) begin
          if (next_label_q >= LabelW'(LabelMax)) begin
            next_label_d = LabelW'(LabelMax);
            ovf_d        = 1'b1;
            lab_d        = LabelW'(LabelMax);
          end else begin
            next_label_d = next_label_q + LabelW'(1);
            lab_d        = next_label_q + LabelW'(1);
          end
        end else if (up_lab == '0) begin
          lab_d = left_q;
        end else begin
          lab_d = (left_q == '0) ? up_lab : left_q;
        end
      end
    end

    // Chain walk: follow parent, switch to the upper chain, resolve, link the roots
    if (cmd_i.walk_step) begin
      cur_d = par_val;
    end
    if (cmd_i.walk_to_up) begin
      ra_d  = cur_q;
      cur_d = up_q;
    end
    if (cmd_i.resolve) begin
      lab_d = cur_q;
    end
    if (do_link) begin
      pvalid_d[ra_q] = 1'b1;
    end

    // Commit: store label in the row buffer and advance the position
    if (cmd_i.commit) begin
      left_d = lab_q;
      if ({1'b0, col_q} == fill_q) begin
        fill_d = fill_q + FillW'(1);
      end
      if (col_next >= w_use) begin
        col_d   = '0;
        first_d = 1'b0;
        left_d  = '0;
      end else begin
        col_d = col_next[ColW-1:0];
      end
    end

    // Result register
    if (cmd_i.out_load) begin
      res_d.label    = lab_q;
      res_d.overflow = ovf_q;
    end
  end

  // Output beat handshake
  always_comb begin
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= WidthW'(WidthReset);
      col_q         <= '0;
      first_q       <= 1'b1;
      left_q        <= '0;
      next_label_q  <= '0;
      ovf_q         <= 1'b0;
      fill_q        <= '0;
      pvalid_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      image_width_q <= image_width_d;
      col_q         <= col_d;
      first_q       <= first_d;
      left_q        <= left_d;
      next_label_q  <= next_label_d;
      ovf_q         <= ovf_d;
      fill_q        <= fill_d;
      pvalid_q      <= pvalid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q       <= pix_d;
    lab_q       <= lab_d;
    cur_q       <= cur_d;
    up_q        <= up_d;
    ra_q        <= ra_d;
    res_q       <= res_d;
    prd_valid_q <= pvalid_q[cur_q];
  end

  // Previous-row labels
  tpcl_ram #(
    .Width (LabelW),
    .Depth (MaxWidth)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (col_q),
    .wdata_i (lab_q),
    .raddr_i (col_q),
    .rdata_o (row_rdata)
  );

  // Parent equivalence table
  tpcl_ram #(
    .Width (LabelW),
    .Depth (LabelCount)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (do_link),
    .waddr_i (ra_q),
    .wdata_i (cur_q),
    .raddr_i (cur_q),
    .rdata_o (par_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `TPCL_ASSERT(a_link_marks_valid, do_link |=> pvalid_q[$past(ra_q)])
  `TPCL_ASSERT(a_commit_col_in_row, cmd_i.commit |=> ({1'b0, col_q} < w_use))
  `TPCL_ASSERT_NEVER(a_ovf_without_labels, ovf_q && (next_label_q != LabelW'(LabelMax)))

endmodule
`default_nettype wire
